// ===== rtl/alh_pkg.sv =====
// Shared types and constants for the alert level hysteresis block.
`default_nettype none

package alh_pkg;

  // event kinds
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_FIRST  = 3'd1;
  localparam logic [2:0] KIND_SECOND = 3'd2;
  localparam logic [2:0] KIND_MOVE   = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // register indexes
  localparam logic [2:0] REG_LOW_BAND    = 3'd0;
  localparam logic [2:0] REG_MEDIUM_BAND = 3'd1;
  localparam logic [2:0] REG_HIGH_BAND   = 3'd2;
  localparam logic [2:0] REG_STAT_GAIN   = 3'd3;
  localparam logic [2:0] REG_FRESHNESS   = 3'd4;
  localparam logic [2:0] REG_LATCH_MODE  = 3'd5;
  localparam logic [2:0] REG_MOVE_HOLD   = 3'd6;
  localparam logic [2:0] REG_STAT_HOLD   = 3'd7;

  // alert levels
  localparam logic [1:0] LVL_NORMAL = 2'd0;
  localparam logic [1:0] LVL_LOW    = 2'd1;
  localparam logic [1:0] LVL_MEDIUM = 2'd2;
  localparam logic [1:0] LVL_HIGH   = 2'd3;

  localparam logic [1:0] LATCH_NONE = 2'd0;

  localparam logic [15:0] SCORE_ONE  = 16'h8000;
  localparam logic [19:0] US_PER_SEC = 20'd1000000;
  localparam int          US_W       = 36;  // 65535 s in microseconds fits 36 bits

  typedef struct packed {
    logic [31:0]     low_band;
    logic [31:0]     medium_band;
    logic [31:0]     high_band;
    logic [15:0]     gain;
    logic [US_W-1:0] fresh_limit;
    logic [1:0]      latch_mode;
    logic [US_W-1:0] move_hold;
    logic [US_W-1:0] stat_hold;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] time_us;
    logic [15:0] score;
    logic        moving;
    logic        baseline_active;
  } item_t;

  typedef struct packed {
    logic [1:0]  alert_level;
    logic [15:0] combined_score;
    logic        moving_mode;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/alh_core.sv =====
// Tracker state and its combinational update for one event, registered on each beat.
`default_nettype none

module alh_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire alh_pkg::cfg_t    cfg,
  input  wire logic             fire,
  input  wire alh_pkg::item_t   item,
  output alh_pkg::result_t      res
);

  logic [1:0]  level_r, level_nxt;
  logic        latched_r, latched_nxt;
  logic [1:0]  floor_r, floor_nxt;
  logic        mode_r, mode_nxt;
  logic [63:0] move_since_r, move_since_nxt;
  logic [63:0] stat_since_r, stat_since_nxt;
  logic [15:0] first_score_r, first_score_nxt;
  logic [63:0] first_time_r, first_time_nxt;
  logic        first_valid_r, first_valid_nxt;
  logic [15:0] second_score_r, second_score_nxt;
  logic [63:0] second_time_r, second_time_nxt;
  logic        second_valid_r, second_valid_nxt;
  logic [15:0] comb_r, comb_nxt;

  logic [15:0] sc_sat;
  logic [63:0] age_a, age_b;
  logic        fresh_a, fresh_b;
  logic [15:0] sa, sb, s_max, s_scaled, s_tick;
  logic [31:0] prod;
  logic [1:0]  lvl_hys, lvl_t, floor_t;
  logic        latched_t;
  logic [63:0] since_t;
  logic [63:0] held;
  logic        hold_zero, hold_done;

  always_comb begin
    sc_sat = (item.score > alh_pkg::SCORE_ONE) ? alh_pkg::SCORE_ONE : item.score;

    // freshness of the stored scores
    age_a   = item.time_us - first_time_r;
    age_b   = item.time_us - second_time_r;
    fresh_a = first_valid_r && (first_time_r != 64'd0) && (item.time_us >= first_time_r)
              && (age_a <= {{(64 - alh_pkg::US_W){1'b0}}, cfg.fresh_limit});
    fresh_b = second_valid_r && (second_time_r != 64'd0) && (item.time_us >= second_time_r)
              && (age_b <= {{(64 - alh_pkg::US_W){1'b0}}, cfg.fresh_limit});
    sa    = fresh_a ? first_score_r : 16'd0;
    sb    = fresh_b ? second_score_r : 16'd0;
    s_max = (sa > sb) ? sa : sb;

    // Q1.15 x Q4.12, back to Q1.15, saturate at 1.0
    prod     = 32'(s_max) * 32'(cfg.gain);
    s_scaled = (prod[31:12] > {4'd0, alh_pkg::SCORE_ONE}) ? alh_pkg::SCORE_ONE : prod[27:12];
    s_tick   = mode_r ? s_max : s_scaled;

    // enter/exit hysteresis
    lvl_hys = level_r;
    case (level_r)
      alh_pkg::LVL_NORMAL: begin
        if (s_tick >= cfg.low_band[31:16]) lvl_hys = alh_pkg::LVL_LOW;
      end
      alh_pkg::LVL_LOW: begin
        if (s_tick >= cfg.medium_band[31:16]) lvl_hys = alh_pkg::LVL_MEDIUM;
        else if (s_tick < cfg.low_band[15:0]) lvl_hys = alh_pkg::LVL_NORMAL;
      end
      alh_pkg::LVL_MEDIUM: begin
        if (s_tick >= cfg.high_band[31:16]) lvl_hys = alh_pkg::LVL_HIGH;
        else if (s_tick < cfg.medium_band[15:0]) lvl_hys = alh_pkg::LVL_LOW;
      end
      default: begin
        if (s_tick < cfg.high_band[15:0]) lvl_hys = alh_pkg::LVL_MEDIUM;
      end
    endcase

    latched_t = latched_r;
    floor_t   = floor_r;
    lvl_t     = lvl_hys;
    if (cfg.latch_mode != alh_pkg::LATCH_NONE) begin
      latched_t = latched_r || (lvl_hys != alh_pkg::LVL_NORMAL);
      if (latched_t) begin
        if (lvl_hys > floor_r) floor_t = lvl_hys;
        // mode bit 1 holds the peak; mode three behaves the same
        if (cfg.latch_mode[1]) begin
          if (lvl_hys < floor_t) lvl_t = floor_t;
        end else if (lvl_hys == alh_pkg::LVL_NORMAL) begin
          lvl_t = alh_pkg::LVL_LOW;
        end
      end
    end

    // movement hold timers, one per direction, sharing one compare
    since_t   = item.moving ? move_since_r : stat_since_r;
    if (since_t == 64'd0) since_t = item.time_us;
    held      = item.time_us - since_t;
    hold_zero = item.moving ? (cfg.move_hold == '0) : (cfg.stat_hold == '0);
    hold_done = hold_zero || ((item.time_us >= since_t) && (held >= {{(64 - alh_pkg::US_W){1'b0}},
                (item.moving ? cfg.move_hold : cfg.stat_hold)}));

    level_nxt        = level_r;
    latched_nxt      = latched_r;
    floor_nxt        = floor_r;
    mode_nxt         = mode_r;
    move_since_nxt   = move_since_r;
    stat_since_nxt   = stat_since_r;
    first_score_nxt  = first_score_r;
    first_time_nxt   = first_time_r;
    first_valid_nxt  = first_valid_r;
    second_score_nxt = second_score_r;
    second_time_nxt  = second_time_r;
    second_valid_nxt = second_valid_r;
    comb_nxt         = comb_r;

    case (item.kind)
      alh_pkg::KIND_TICK: begin
        if (item.baseline_active) begin
          level_nxt   = alh_pkg::LVL_NORMAL;
          latched_nxt = 1'b0;
          floor_nxt   = alh_pkg::LVL_NORMAL;
        end else begin
          comb_nxt    = s_tick;
          level_nxt   = lvl_t;
          latched_nxt = latched_t;
          floor_nxt   = floor_t;
        end
      end
      alh_pkg::KIND_FIRST: begin
        first_score_nxt = sc_sat;
        first_time_nxt  = item.time_us;
        first_valid_nxt = 1'b1;
      end
      alh_pkg::KIND_SECOND: begin
        second_score_nxt = sc_sat;
        second_time_nxt  = item.time_us;
        second_valid_nxt = 1'b1;
      end
      alh_pkg::KIND_MOVE: begin
        if (item.moving == mode_r) begin
          move_since_nxt = 64'd0;
          stat_since_nxt = 64'd0;
        end else if (item.moving) begin
          stat_since_nxt = 64'd0;
          move_since_nxt = hold_done ? 64'd0 : since_t;
          if (hold_done) mode_nxt = 1'b1;
        end else begin
          move_since_nxt = 64'd0;
          stat_since_nxt = hold_done ? 64'd0 : since_t;
          if (hold_done) mode_nxt = 1'b0;
        end
      end
      alh_pkg::KIND_CLEAR: begin
        level_nxt        = alh_pkg::LVL_NORMAL;
        latched_nxt      = 1'b0;
        floor_nxt        = alh_pkg::LVL_NORMAL;
        mode_nxt         = 1'b0;
        move_since_nxt   = 64'd0;
        stat_since_nxt   = 64'd0;
        first_score_nxt  = 16'd0;
        first_time_nxt   = 64'd0;
        first_valid_nxt  = 1'b0;
        second_score_nxt = 16'd0;
        second_time_nxt  = 64'd0;
        second_valid_nxt = 1'b0;
        comb_nxt         = 16'd0;
      end
      default: begin
      end
    endcase

    res.alert_level    = level_nxt;
    res.combined_score = comb_nxt;
    res.moving_mode    = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r        <= alh_pkg::LVL_NORMAL;
      latched_r      <= 1'b0;
      floor_r        <= alh_pkg::LVL_NORMAL;
      mode_r         <= 1'b0;
      move_since_r   <= 64'd0;
      stat_since_r   <= 64'd0;
      first_score_r  <= 16'd0;
      first_time_r   <= 64'd0;
      first_valid_r  <= 1'b0;
      second_score_r <= 16'd0;
      second_time_r  <= 64'd0;
      second_valid_r <= 1'b0;
      comb_r         <= 16'd0;
    end else if (fire) begin
      level_r        <= level_nxt;
      latched_r      <= latched_nxt;
      floor_r        <= floor_nxt;
      mode_r         <= mode_nxt;
      move_since_r   <= move_since_nxt;
      stat_since_r   <= stat_since_nxt;
      first_score_r  <= first_score_nxt;
      first_time_r   <= first_time_nxt;
      first_valid_r  <= first_valid_nxt;
      second_score_r <= second_score_nxt;
      second_time_r  <= second_time_nxt;
      second_valid_r <= second_valid_nxt;
      comb_r         <= comb_nxt;
    end
  end

  a_comb_sat: assert property (@(posedge clk) disable iff (!rst_n)
    comb_r <= alh_pkg::SCORE_ONE)
    else $error("combined score above 1.0");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.kind == alh_pkg::KIND_CLEAR) |=>
      (level_r == alh_pkg::LVL_NORMAL) && !mode_r && (comb_r == 16'd0) && !first_valid_r
      && !second_valid_r)
    else $error("clear left state behind");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(level_r) && $stable(mode_r) && $stable(comb_r))
    else $error("state moved without a beat");

  a_no_since_in_mode: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r |-> (stat_since_r == 64'd0) || (move_since_r == 64'd0))
    else $error("both hold timers running");

endmodule

`default_nettype wire

// ===== rtl/alert_level_hysteresis.sv =====
// Alert level controller: four-level alert from timed score, movement and tick events.
//
// Usage:
//   in_*   : one event per beat (tick, first score, second score, movement, clear).
//   out_*  : exactly one result beat per event: alert level, combined score, moving mode.
//   cfg_*  : register writes, index 0..7, always accepted (cfg_ready is always high);
//            write only while no event is in flight.
// Path: an accepted event is registered in the input register and worked on from there;
// its result is registered in the result register, which drives out_valid, once the
// result register is free or its beat is being taken.
// Throughput: one event per cycle while out_ready stays high. The score path (freshness
// compares, a 16x16 gain multiply, threshold compares) is combinational between the input
// and result registers; the tracker state is registered with the result, so the next event sees it.
// Stall: a waiting result holds in its register while out_ready is low; the input register
// still takes one more event, after which in_ready drops until the result is taken.
// Reset (rst_n low at a clock edge) empties both registers, restores the register
// defaults and clears the tracker state.
`default_nettype none

module alert_level_hysteresis (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [63:0] in_time_us,
  input  wire logic [15:0] in_score,
  input  wire logic        in_moving,
  input  wire logic        in_baseline_active,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_alert_level,
  output logic [15:0]      out_combined_score,
  output logic             out_moving_mode,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  alh_pkg::cfg_t    cfg_r;
  logic             in_v_r;
  alh_pkg::item_t   in_item_r;
  logic             out_v_r;
  alh_pkg::result_t out_res_r;
  alh_pkg::result_t res;
  logic             adv;
  logic [alh_pkg::US_W-1:0] cfg_us;

  assign adv       = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || adv;
  assign cfg_ready = 1'b1;

  // seconds to microseconds, done once at write time
  assign cfg_us = alh_pkg::US_W'(cfg_data[15:0]) * alh_pkg::US_W'(alh_pkg::US_PER_SEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_band    <= 32'd2147496755;
      cfg_r.medium_band <= 32'd2621460480;
      cfg_r.high_band   <= 32'd3145755034;
      cfg_r.gain        <= 16'd4096;
      cfg_r.fresh_limit <= alh_pkg::US_W'(30000000);
      cfg_r.latch_mode  <= alh_pkg::LATCH_NONE;
      cfg_r.move_hold   <= alh_pkg::US_W'(10000000);
      cfg_r.stat_hold   <= alh_pkg::US_W'(10000000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        alh_pkg::REG_LOW_BAND:    cfg_r.low_band    <= cfg_data;
        alh_pkg::REG_MEDIUM_BAND: cfg_r.medium_band <= cfg_data;
        alh_pkg::REG_HIGH_BAND:   cfg_r.high_band   <= cfg_data;
        alh_pkg::REG_STAT_GAIN:   cfg_r.gain        <= cfg_data[15:0];
        alh_pkg::REG_FRESHNESS:   cfg_r.fresh_limit <= cfg_us;
        alh_pkg::REG_LATCH_MODE:  cfg_r.latch_mode  <= cfg_data[1:0];
        alh_pkg::REG_MOVE_HOLD:   cfg_r.move_hold   <= cfg_us;
        alh_pkg::REG_STAT_HOLD:   cfg_r.stat_hold   <= cfg_us;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) in_v_r <= in_valid;
      if (adv) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r.kind            <= in_kind;
      in_item_r.time_us         <= in_time_us;
      in_item_r.score           <= in_score;
      in_item_r.moving          <= in_moving;
      in_item_r.baseline_active <= in_baseline_active;
    end
    if (adv) out_res_r <= res;
  end

  alh_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (adv),
    .item  (in_item_r),
    .res   (res)
  );

  assign out_valid          = out_v_r;
  assign out_alert_level    = out_res_r.alert_level;
  assign out_combined_score = out_res_r.combined_score;
  assign out_moving_mode    = out_res_r.moving_mode;

  // a waiting event never passes a result that has not been taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ready |=> out_v_r && $stable(out_res_r))
    else $error("result beat overwritten while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r && $stable(in_item_r))
    else $error("held input beat changed");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("worked beat produced no result");

endmodule

`default_nettype wire

// ===== tb/tb_alert_level_hysteresis.sv =====
// Self-checking testbench for alert_level_hysteresis: directed cases, then random event traffic.

module tb_alert_level_hysteresis;

  localparam logic [2:0]  KIND_SPARE_A   = 3'd5;
  localparam logic [2:0]  KIND_SPARE_B   = 3'd6;
  localparam logic [2:0]  KIND_SPARE_C   = 3'd7;
  localparam logic [1:0]  LATCH_FLOOR    = 2'd1;
  localparam logic [1:0]  LATCH_PEAK     = 2'd2;
  localparam logic [1:0]  LATCH_PEAK_ALT = 2'd3;
  localparam logic [63:0] US_PER_S       = 64'd1000000;
  localparam logic [63:0] TIME_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          QUIET_LIMIT    = 2000;
  localparam int          EXP_DEPTH      = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = '0;
  logic [63:0] in_time_us = '0;
  logic [15:0] in_score = '0;
  logic        in_moving = 1'b0;
  logic        in_baseline_active = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_alert_level;
  logic [15:0] out_combined_score;
  logic        out_moving_mode;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #10 clk = ~clk;

  alert_level_hysteresis uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_time_us         (in_time_us),
    .in_score           (in_score),
    .in_moving          (in_moving),
    .in_baseline_active (in_baseline_active),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_alert_level    (out_alert_level),
    .out_combined_score (out_combined_score),
    .out_moving_mode    (out_moving_mode),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // predictor copy of the registers
  logic [31:0] band_low, band_med, band_high;
  logic [15:0] gain_q412, fresh_s, hold_mv_s, hold_st_s;
  logic [1:0]  latch_sel;

  // predictor copy of the tracker state
  logic [1:0]  cur_level, peak_level;
  logic        latch_armed, trk_moving;
  logic [63:0] mv_start, st_start;
  logic [15:0] src_a_score, src_b_score, held_score;
  logic [63:0] src_a_time, src_b_time;
  logic        src_a_valid, src_b_valid;

  // expected result beats, written on input accept, read on result accept
  alh_pkg::result_t exp_beats [EXP_DEPTH];
  int          sent_cnt = 0;
  int          taken_cnt = 0;
  alh_pkg::result_t want;
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_off_req = 0;
  int          hold_off_left = 0;
  int          quiet_cycles = 0;
  logic [63:0] stamp;
  logic        motion_bias;

  function automatic void clear_tracker();
    cur_level   = alh_pkg::LVL_NORMAL;
    peak_level  = alh_pkg::LVL_NORMAL;
    latch_armed = 1'b0;
    trk_moving  = 1'b0;
    mv_start    = '0;
    st_start    = '0;
    src_a_score = '0;
    src_a_time  = '0;
    src_a_valid = 1'b0;
    src_b_score = '0;
    src_b_time  = '0;
    src_b_valid = 1'b0;
    held_score  = '0;
  endfunction

  function automatic logic [15:0] fresh_or_zero(logic ok, logic [63:0] t, logic [15:0] s,
                                                logic [63:0] now);
    logic [63:0] lim;
    lim = 64'(fresh_s) * US_PER_S;
    if (ok && t != 0 && now >= t && now - t <= lim) return s;
    return 16'd0;
  endfunction

  function automatic alh_pkg::result_t predict_event(logic [2:0] kind, logic [63:0] now,
                                                     logic [15:0] score, logic mv, logic bl);
    alh_pkg::result_t r;
    logic [15:0] sc, va, vb, best;
    logic [63:0] prod, hold;
    sc = (score > alh_pkg::SCORE_ONE) ? alh_pkg::SCORE_ONE : score;
    case (kind)
      alh_pkg::KIND_TICK: begin
        if (bl) begin
          // baseline capture: level drops, combined score is left alone
          cur_level   = alh_pkg::LVL_NORMAL;
          latch_armed = 1'b0;
          peak_level  = alh_pkg::LVL_NORMAL;
        end else begin
          va = fresh_or_zero(src_a_valid, src_a_time, src_a_score, now);
          vb = fresh_or_zero(src_b_valid, src_b_time, src_b_score, now);
          best = (va > vb) ? va : vb;
          if (!trk_moving) begin
            prod = (64'(best) * 64'(gain_q412)) >> 12;
            best = (prod > 64'(alh_pkg::SCORE_ONE)) ? alh_pkg::SCORE_ONE : prod[15:0];
          end
          held_score = best;
          case (cur_level)
            alh_pkg::LVL_NORMAL: begin
              if (best >= band_low[31:16]) cur_level = alh_pkg::LVL_LOW;
            end
            alh_pkg::LVL_LOW: begin
              if (best >= band_med[31:16]) cur_level = alh_pkg::LVL_MEDIUM;
              else if (best < band_low[15:0]) cur_level = alh_pkg::LVL_NORMAL;
            end
            alh_pkg::LVL_MEDIUM: begin
              if (best >= band_high[31:16]) cur_level = alh_pkg::LVL_HIGH;
              else if (best < band_med[15:0]) cur_level = alh_pkg::LVL_LOW;
            end
            default: begin
              if (best < band_high[15:0]) cur_level = alh_pkg::LVL_MEDIUM;
            end
          endcase
          if (latch_sel != alh_pkg::LATCH_NONE) begin
            if (cur_level != alh_pkg::LVL_NORMAL) latch_armed = 1'b1;
            if (latch_armed) begin
              if (cur_level > peak_level) peak_level = cur_level;
              if (latch_sel == LATCH_PEAK || latch_sel == LATCH_PEAK_ALT) begin
                if (cur_level < peak_level) cur_level = peak_level;
              end else if (cur_level == alh_pkg::LVL_NORMAL) begin
                cur_level = alh_pkg::LVL_LOW;
              end
            end
          end
        end
      end
      alh_pkg::KIND_FIRST: begin
        src_a_score = sc;
        src_a_time  = now;
        src_a_valid = 1'b1;
      end
      alh_pkg::KIND_SECOND: begin
        src_b_score = sc;
        src_b_time  = now;
        src_b_valid = 1'b1;
      end
      alh_pkg::KIND_MOVE: begin
        if (mv == trk_moving) begin
          mv_start = '0;
          st_start = '0;
        end else if (mv) begin
          // a start time of zero reads as unset
          if (mv_start == 0) mv_start = now;
          st_start = '0;
          hold = 64'(hold_mv_s) * US_PER_S;
          if (hold == 0 || (now >= mv_start && now - mv_start >= hold)) begin
            trk_moving = 1'b1;
            mv_start   = '0;
          end
        end else begin
          if (st_start == 0) st_start = now;
          mv_start = '0;
          hold = 64'(hold_st_s) * US_PER_S;
          if (hold == 0 || (now >= st_start && now - st_start >= hold)) begin
            trk_moving = 1'b0;
            st_start   = '0;
          end
        end
      end
      alh_pkg::KIND_CLEAR: clear_tracker();
      default: ;
    endcase
    r.alert_level    = cur_level;
    r.combined_score = held_score;
    r.moving_mode    = trk_moving;
    return r;
  endfunction

  // one event beat; valid stays up between back-to-back beats
  task automatic send_event(input logic [2:0] kind, input logic [63:0] now,
                            input logic [15:0] score, input logic mv, input logic bl);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid           <= 1'b1;
    in_kind            <= kind;
    in_time_us         <= now;
    in_score           <= score;
    in_moving          <= mv;
    in_baseline_active <= bl;
    do @(posedge clk); while (!in_ready);
    exp_beats[6'(sent_cnt)] = predict_event(kind, now, score, mv, bl);
    sent_cnt++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sent_cnt != taken_cnt) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_registers(input logic [31:0] lo, md, hi, input logic [15:0] gain, fresh,
                               input logic [1:0] latch, input logic [15:0] mhold, shold);
    logic [31:0] regval [8];
    drain();
    regval[alh_pkg::REG_LOW_BAND]    = lo;
    regval[alh_pkg::REG_MEDIUM_BAND] = md;
    regval[alh_pkg::REG_HIGH_BAND]   = hi;
    regval[alh_pkg::REG_STAT_GAIN]   = 32'(gain);
    regval[alh_pkg::REG_FRESHNESS]   = 32'(fresh);
    regval[alh_pkg::REG_LATCH_MODE]  = 32'(latch);
    regval[alh_pkg::REG_MOVE_HOLD]   = 32'(mhold);
    regval[alh_pkg::REG_STAT_HOLD]   = 32'(shold);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= regval[i];
      do @(posedge clk); while (!cfg_ready);
      case (3'(i))
        alh_pkg::REG_LOW_BAND:    band_low  = regval[i];
        alh_pkg::REG_MEDIUM_BAND: band_med  = regval[i];
        alh_pkg::REG_HIGH_BAND:   band_high = regval[i];
        alh_pkg::REG_STAT_GAIN:   gain_q412 = regval[i][15:0];
        alh_pkg::REG_FRESHNESS:   fresh_s   = regval[i][15:0];
        alh_pkg::REG_LATCH_MODE:  latch_sel = regval[i][1:0];
        alh_pkg::REG_MOVE_HOLD:   hold_mv_s = regval[i][15:0];
        default:                  hold_st_s = regval[i][15:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // well-formed timeline with random content, plus a share of noise
  function automatic void make_event(output logic [2:0] kind, output logic [63:0] now,
                                     output logic [15:0] score, output logic mv,
                                     output logic bl);
    int pick;
    case ($urandom_range(9))
      0:       stamp = stamp;
      1:       stamp = stamp + 64'($urandom_range(1000));
      2:       stamp = stamp + 64'(fresh_s) * US_PER_S;
      3:       stamp = stamp + 64'(hold_mv_s) * US_PER_S;
      4:       stamp = stamp + 64'(hold_st_s) * US_PER_S;
      5:       stamp = stamp + 64'($urandom_range(20)) * US_PER_S;
      default: stamp = stamp + 64'($urandom_range(3000000));
    endcase
    now = stamp;
    case ($urandom_range(9))
      0:       score = 16'd0;
      1:       score = alh_pkg::SCORE_ONE;
      2:       score = 16'($urandom_range(16'hFFFF, 16'h8001));
      3:       score = band_low[31:16];
      4:       score = band_med[31:16];
      5:       score = band_high[15:0];
      default: score = 16'($urandom_range(alh_pkg::SCORE_ONE));
    endcase
    mv = 1'($urandom_range(1));
    bl = ($urandom_range(9) == 0);
    pick = $urandom_range(99);
    if (pick < 35) begin
      kind = alh_pkg::KIND_TICK;
    end else if (pick < 50) begin
      kind = alh_pkg::KIND_FIRST;
    end else if (pick < 65) begin
      kind = alh_pkg::KIND_SECOND;
    end else if (pick < 88) begin
      kind = alh_pkg::KIND_MOVE;
      if ($urandom_range(9) == 0) motion_bias = ~motion_bias;
      mv = ($urandom_range(7) == 0) ? ~motion_bias : motion_bias;
    end else if (pick < 91) begin
      kind = alh_pkg::KIND_CLEAR;
    end else if (pick < 94) begin
      kind = 3'($urandom_range(KIND_SPARE_C, KIND_SPARE_A));
    end else begin
      kind = 3'($urandom);
      now  = {$urandom, $urandom};
    end
  endfunction

  task automatic test_special_cases();
    // reset registers: low enter 1.0, gain 1.0, 30 s freshness, 10 s holds
    send_event(alh_pkg::KIND_TICK, 64'd0, 16'd0, 1'b0, 1'b0);
    send_event(alh_pkg::KIND_TICK, 5 * US_PER_S, 16'hFFFF, 1'b1, 1'b1);
    send_event(alh_pkg::KIND_FIRST, US_PER_S, 16'hFFFF, 1'b0, 1'b0);
    send_event(alh_pkg::KIND_SECOND, US_PER_S, 16'h4000, 1'b1, 1'b0);
    send_event(alh_pkg::KIND_TICK, 2 * US_PER_S, 16'd0, 1'b0, 1'b0);
    send_event(alh_pkg::KIND_TICK, 31 * US_PER_S, 16'd0, 1'b0, 1'b0);
    send_event(alh_pkg::KIND_TICK, 31 * US_PER_S + 1, 16'd0, 1'b0, 1'b0);
    send_event(alh_pkg::KIND_TICK, 64'd0, 16'd0, 1'b0, 1'b0);
    // observation at time zero leaves the hold timer unset
    send_event(alh_pkg::KIND_MOVE, 64'd0, 16'd0, 1'b1, 1'b0);
    send_event(alh_pkg::KIND_MOVE, 3 * US_PER_S, 16'd0, 1'b1, 1'b0);
    send_event(alh_pkg::KIND_MOVE, 13 * US_PER_S - 1, 16'd0, 1'b1, 1'b0);
    send_event(alh_pkg::KIND_MOVE, 13 * US_PER_S, 16'd0, 1'b1, 1'b0);
    send_event(alh_pkg::KIND_FIRST, 14 * US_PER_S, 16'h6000, 1'b0, 1'b0);
    send_event(alh_pkg::KIND_TICK, 14 * US_PER_S, 16'd0, 1'b0, 1'b0);
    send_event(KIND_SPARE_A, TIME_MAX, 16'hFFFF, 1'b1, 1'b1);
    send_event(KIND_SPARE_B, 64'd0, 16'h8000, 1'b0, 1'b1);
    send_event(KIND_SPARE_C, 15 * US_PER_S, 16'h1234, 1'b1, 1'b0);
    send_event(alh_pkg::KIND_TICK, TIME_MAX, 16'd0, 1'b0, 1'b0);
    send_event(alh_pkg::KIND_CLEAR, TIME_MAX, 16'hFFFF, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_latching();
    // gain of 2.0 saturates, zero holds switch mode at once
    set_registers({16'h1000, 16'h0800}, {16'h3000, 16'h2000}, {16'h6000, 16'h5000},
                  16'h2000, 16'hFFFF, LATCH_FLOOR, 16'd0, 16'd0);
    send_event(alh_pkg::KIND_FIRST, US_PER_S, 16'h5000, 1'b0, 1'b0);
    repeat (3) send_event(alh_pkg::KIND_TICK, US_PER_S, 16'd0, 1'b0, 1'b0);
    send_event(alh_pkg::KIND_FIRST, 2 * US_PER_S, 16'd0, 1'b0, 1'b0);
    repeat (3) send_event(alh_pkg::KIND_TICK, 2 * US_PER_S, 16'd0, 1'b0, 1'b0);
    set_registers({16'h1000, 16'h0800}, {16'h3000, 16'h2000}, {16'h6000, 16'h5000},
                  16'h2000, 16'hFFFF, LATCH_PEAK_ALT, 16'd0, 16'd0);
    send_event(alh_pkg::KIND_CLEAR, 64'd0, 16'd0, 1'b0, 1'b0);
    send_event(alh_pkg::KIND_MOVE, US_PER_S, 16'd0, 1'b1, 1'b0);
    send_event(alh_pkg::KIND_FIRST, US_PER_S, 16'h3000, 1'b0, 1'b0);
    repeat (2) send_event(alh_pkg::KIND_TICK, US_PER_S, 16'd0, 1'b0, 1'b0);
    send_event(alh_pkg::KIND_FIRST, 2 * US_PER_S, 16'd0, 1'b0, 1'b0);
    send_event(alh_pkg::KIND_TICK, 2 * US_PER_S, 16'd0, 1'b0, 1'b0);
    send_event(alh_pkg::KIND_MOVE, 3 * US_PER_S, 16'd0, 1'b0, 1'b0);
    drain();
  endtask

  task automatic test_random_traffic(input int count);
    logic [2:0]  kind;
    logic [63:0] now;
    logic [15:0] score;
    logic        mv, bl;
    stamp = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(1000));
    motion_bias = trk_moving;
    repeat (count) begin
      make_event(kind, now, score, mv, bl);
      send_event(kind, now, score, mv, bl);
    end
    drain();
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_off_req <= 64;
    test_random_traffic(24);
  endtask

  task automatic randomise_registers(input int sel);
    logic [15:0] le, lx, me, mx, he, hx, gain, fresh, mhold, shold;
    logic [31:0] lo, md, hi;
    logic [1:0]  latch;
    if (sel == 0) begin
      set_registers('0, '0, '0, '0, '0, alh_pkg::LATCH_NONE, '0, '0);
    end else if (sel == 1) begin
      set_registers('1, '1, '1, '1, '1, LATCH_PEAK, '1, '1);
    end else begin
      le = 16'($urandom_range(16'h8400));
      lx = 16'($urandom_range(le));
      me = 16'($urandom_range(16'h8400));
      mx = 16'($urandom_range(me));
      he = 16'($urandom_range(16'h8400));
      hx = 16'($urandom_range(he));
      lo = {le, lx};
      md = {me, mx};
      hi = {he, hx};
      if ($urandom_range(7) == 0) lo = $urandom;
      if ($urandom_range(7) == 0) hi = $urandom;
      case ($urandom_range(2))
        0:       gain = 16'h1000;
        1:       gain = 16'($urandom);
        default: gain = 16'($urandom_range(16'h2000, 16'h0800));
      endcase
      fresh = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(40));
      latch = 2'($urandom_range(LATCH_PEAK_ALT));
      mhold = 16'($urandom_range(15));
      shold = 16'($urandom_range(15));
      set_registers(lo, md, hi, gain, fresh, latch, mhold, shold);
    end
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_off_req != 0) begin
      hold_off_left = hold_off_req;
      hold_off_req <= 0;
    end
    if (hold_off_left != 0) begin
      hold_off_left = hold_off_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (taken_cnt == sent_cnt) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual level %0d score %0d mode %0d",
                 $time, out_alert_level, out_combined_score, out_moving_mode);
      end else begin
        want = exp_beats[6'(taken_cnt)];
        taken_cnt++;
        if (out_alert_level !== want.alert_level) begin
          errors++;
          $display("%0t: alert_level expected %0d actual %0d",
                   $time, want.alert_level, out_alert_level);
        end
        if (out_combined_score !== want.combined_score) begin
          errors++;
          $display("%0t: combined_score expected %0d actual %0d",
                   $time, want.combined_score, out_combined_score);
        end
        if (out_moving_mode !== want.moving_mode) begin
          errors++;
          $display("%0t: moving_mode expected %0d actual %0d",
                   $time, want.moving_mode, out_moving_mode);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    band_low  = 32'd2147496755;
    band_med  = 32'd2621460480;
    band_high = 32'd3145755034;
    gain_q412 = 16'd4096;
    fresh_s   = 16'd30;
    latch_sel = alh_pkg::LATCH_NONE;
    hold_mv_s = 16'd10;
    hold_st_s = 16'd10;
    clear_tracker();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_special_cases();
    test_latching();
    test_backpressure();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 46;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 46;
        end
        default: begin
          idle_pct  = 35;
          stall_pct = 35;
        end
      endcase
      for (int k = 0; k < 4; k++) begin
        randomise_registers(k);
        test_random_traffic(100);
      end
    end
    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/alh_pkg.sv
rtl/alh_core.sv
rtl/alert_level_hysteresis.sv
tb/tb_alert_level_hysteresis.sv
